>>> design/gpc_pkg.sv
// shared types and constants of the gpio pin controller
`default_nettype none
package gpc_pkg;

    localparam int unsigned VEC_W  = 30;
    localparam int unsigned FUNC_W = 5;
    localparam int unsigned PAD_W  = 9;
    localparam int unsigned ARG_W  = 5;

    typedef enum logic [3:0] {
        CMD_PROBE = 4'd0,
        CMD_MODE  = 4'd1,
        CMD_PULL  = 4'd2,
        CMD_TYPE  = 4'd3,
        CMD_ALTF  = 4'd4,
        CMD_SPEED = 4'd5,
        CMD_SET   = 4'd6,
        CMD_CLEAR = 4'd7,
        CMD_READ  = 4'd8
    } t_cmd;

    localparam logic [ARG_W-1:0] MODE_INPUT  = 5'd0;
    localparam logic [ARG_W-1:0] MODE_OUTPUT = 5'd1;
    localparam logic [ARG_W-1:0] MODE_ALT    = 5'd2;
    localparam logic [ARG_W-1:0] MODE_ANALOG = 5'd3;

    localparam logic [ARG_W-1:0] PULL_NONE = 5'd0;
    localparam logic [ARG_W-1:0] PULL_UP   = 5'd1;
    localparam logic [ARG_W-1:0] PULL_DOWN = 5'd2;

    localparam logic [ARG_W-1:0] TYPE_PUSH_PULL  = 5'd0;
    localparam logic [ARG_W-1:0] TYPE_OPEN_DRAIN = 5'd1;

    localparam logic [ARG_W-1:0] SPEED_MAX       = 5'd3;
    localparam logic [ARG_W-1:0] SPEED_FAST_SLEW = 5'd2;
    localparam logic [ARG_W-1:0] FUNC_MAX        = 5'd10;

    localparam logic [FUNC_W-1:0] FUNC_SIO  = 5'd5;
    localparam logic [FUNC_W-1:0] FUNC_NONE = 5'd31;

    localparam logic [PAD_W-1:0] PAD_ISO     = 9'h100;
    localparam logic [PAD_W-1:0] PAD_IE      = 9'h040;
    localparam logic [PAD_W-1:0] PAD_DRIVE   = 9'h030;
    localparam logic [PAD_W-1:0] PAD_PUE     = 9'h008;
    localparam logic [PAD_W-1:0] PAD_PDE     = 9'h004;
    localparam logic [PAD_W-1:0] PAD_SCHMITT = 9'h002;
    localparam logic [PAD_W-1:0] PAD_SLEW    = 9'h001;
    localparam logic [PAD_W-1:0] PAD_RESET   = 9'h116;
    localparam int unsigned      PAD_DRIVE_SHIFT = 4;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_ctrl_cmd;

endpackage
`default_nettype wire

>>> design/gpc_ctrl.sv
// sequencer of the gpio pin controller: capture, update and output handshake
`default_nettype none
module gpc_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  wire                 i_stall,
    output gpc_pkg::t_ctrl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   capture, execute;

    always_comb begin
        capture = 1'b0;
        execute = 1'b0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                capture = i_valid;
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                execute = !r_out_valid || !i_stall;
                if (execute) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = execute || (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_cmd.capture = capture;
    assign o_cmd.execute = execute;

endmodule
`default_nettype wire

>>> design/gpc_dp.sv
// datapath of the gpio pin controller: pin registers, bank vectors, result register
`default_nettype none
module gpc_dp #(
    parameter int PIN_COUNT = 30
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  gpc_pkg::t_ctrl_cmd           i_cmd,
    input  wire  [3:0]                   i_command,
    input  wire  [7:0]                   i_port_id,
    input  wire  [4:0]                   i_pin_index,
    input  wire  [gpc_pkg::ARG_W-1:0]    i_argument,
    input  wire  [gpc_pkg::VEC_W-1:0]    i_pin_levels,
    output logic                         o_status,
    output logic                         o_read_level,
    output logic [gpc_pkg::VEC_W-1:0]    o_out_latch_vec,
    output logic [gpc_pkg::VEC_W-1:0]    o_out_enable_vec,
    output logic [gpc_pkg::FUNC_W-1:0]   o_pin_function,
    output logic [gpc_pkg::PAD_W-1:0]    o_pin_pad_bits
);

    localparam int IDX_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
    localparam logic [5:0] PIN_LIM = 6'(PIN_COUNT);

    logic [3:0]                 r_command;
    logic [7:0]                 r_port_id;
    logic [4:0]                 r_pin_index;
    logic [gpc_pkg::ARG_W-1:0]  r_argument;
    logic [gpc_pkg::VEC_W-1:0]  r_pin_levels;

    logic [gpc_pkg::FUNC_W-1:0] r_func [PIN_COUNT];
    logic [gpc_pkg::PAD_W-1:0]  r_pad  [PIN_COUNT];
    logic [gpc_pkg::VEC_W-1:0]  r_latch, n_latch;
    logic [gpc_pkg::VEC_W-1:0]  r_oe, n_oe;
    logic [gpc_pkg::VEC_W-1:0]  r_od, n_od;

    logic [IDX_W-1:0]           idx;
    logic                       pin_ok;
    logic [gpc_pkg::VEC_W-1:0]  bit_v;
    logic                       od, lat;
    logic [gpc_pkg::FUNC_W-1:0] cur_f, n_f;
    logic [gpc_pkg::PAD_W-1:0]  cur_p, n_p;
    logic [gpc_pkg::PAD_W-1:0]  pclr, pset;
    logic                       bad, level;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_command    <= i_command;
            r_port_id    <= i_port_id;
            r_pin_index  <= i_pin_index;
            r_argument   <= i_argument;
            r_pin_levels <= i_pin_levels;
        end
    end

    assign pin_ok = {1'b0, r_pin_index} < PIN_LIM;
    assign idx    = r_pin_index[IDX_W-1:0];
    assign bit_v  = pin_ok ? (gpc_pkg::VEC_W'(1) << r_pin_index) : '0;
    assign od     = |(r_od & bit_v);
    assign lat    = |(r_latch & bit_v);
    assign cur_f  = pin_ok ? r_func[idx] : '0;
    assign cur_p  = pin_ok ? r_pad[idx] : '0;
    assign pclr   = gpc_pkg::PAD_ISO | gpc_pkg::PAD_IE;
    assign pset   = gpc_pkg::PAD_SCHMITT | gpc_pkg::PAD_IE;

    always_comb begin
        bad     = 1'b0;
        level   = 1'b0;
        n_latch = r_latch;
        n_oe    = r_oe;
        n_od    = r_od;
        n_f     = cur_f;
        n_p     = cur_p;
        if (r_port_id != 8'd0) begin
            bad = 1'b1;
        end else if (r_command == gpc_pkg::CMD_PROBE) begin
            n_od = '0;
        end else if (!pin_ok || r_command > gpc_pkg::CMD_READ) begin
            bad = 1'b1;
        end else begin
            case (r_command)
                gpc_pkg::CMD_MODE: begin
                    if (r_argument == gpc_pkg::MODE_INPUT) begin
                        n_f  = gpc_pkg::FUNC_SIO;
                        n_p  = (cur_p & ~pclr) | pset;
                        n_oe = r_oe & ~bit_v;
                    end else if (r_argument == gpc_pkg::MODE_OUTPUT) begin
                        n_f = gpc_pkg::FUNC_SIO;
                        n_p = (cur_p & ~pclr) | pset;
                        if (od) begin
                            n_latch = r_latch | bit_v;
                            n_oe    = r_oe & ~bit_v;
                        end else begin
                            n_oe = r_oe | bit_v;
                        end
                    end else if (r_argument == gpc_pkg::MODE_ALT) begin
                        n_p  = (cur_p & ~pclr) | pset;
                        n_oe = r_oe & ~bit_v;
                    end else if (r_argument == gpc_pkg::MODE_ANALOG) begin
                        n_f  = gpc_pkg::FUNC_NONE;
                        n_p  = cur_p & ~(pclr | gpc_pkg::PAD_SCHMITT);
                        n_oe = r_oe & ~bit_v;
                    end else begin
                        bad = 1'b1;
                    end
                end
                gpc_pkg::CMD_PULL: begin
                    if (r_argument == gpc_pkg::PULL_NONE) begin
                        n_p = cur_p & ~(gpc_pkg::PAD_PUE | gpc_pkg::PAD_PDE);
                    end else if (r_argument == gpc_pkg::PULL_UP) begin
                        n_p = (cur_p & ~(gpc_pkg::PAD_PUE | gpc_pkg::PAD_PDE))
                            | gpc_pkg::PAD_PUE;
                    end else if (r_argument == gpc_pkg::PULL_DOWN) begin
                        n_p = (cur_p & ~(gpc_pkg::PAD_PUE | gpc_pkg::PAD_PDE))
                            | gpc_pkg::PAD_PDE;
                    end else begin
                        bad = 1'b1;
                    end
                end
                gpc_pkg::CMD_TYPE: begin
                    if (r_argument == gpc_pkg::TYPE_PUSH_PULL) begin
                        n_od = r_od & ~bit_v;
                        n_oe = r_oe | bit_v;
                    end else if (r_argument == gpc_pkg::TYPE_OPEN_DRAIN) begin
                        n_od = r_od | bit_v;
                        n_oe = lat ? (r_oe & ~bit_v) : (r_oe | bit_v);
                    end else begin
                        bad = 1'b1;
                    end
                end
                gpc_pkg::CMD_ALTF: begin
                    if (r_argument > gpc_pkg::FUNC_MAX) begin
                        bad = 1'b1;
                    end else begin
                        n_f = r_argument;
                    end
                end
                gpc_pkg::CMD_SPEED: begin
                    if (r_argument > gpc_pkg::SPEED_MAX) begin
                        bad = 1'b1;
                    end else begin
                        n_p = (cur_p & ~(gpc_pkg::PAD_DRIVE | gpc_pkg::PAD_SLEW))
                            | (gpc_pkg::PAD_W'(r_argument[1:0]) << gpc_pkg::PAD_DRIVE_SHIFT)
                            | ((r_argument >= gpc_pkg::SPEED_FAST_SLEW) ?
                               gpc_pkg::PAD_SLEW : '0);
                    end
                end
                gpc_pkg::CMD_SET: begin
                    n_latch = r_latch | bit_v;
                    if (od) begin
                        n_oe = r_oe & ~bit_v;
                    end
                end
                gpc_pkg::CMD_CLEAR: begin
                    n_latch = r_latch & ~bit_v;
                    if (od) begin
                        n_oe = r_oe | bit_v;
                    end
                end
                gpc_pkg::CMD_READ: begin
                    level = |(r_pin_levels & bit_v);
                end
                default: begin
                    bad = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch <= '0;
            r_oe    <= '0;
            r_od    <= '0;
            for (int i = 0; i < PIN_COUNT; i++) begin
                r_func[i] <= gpc_pkg::FUNC_NONE;
                r_pad[i]  <= gpc_pkg::PAD_RESET;
            end
        end else if (i_cmd.execute) begin
            r_latch <= n_latch;
            r_oe    <= n_oe;
            r_od    <= n_od;
            if (pin_ok) begin
                r_func[idx] <= n_f;
                r_pad[idx]  <= n_p;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            o_status         <= bad;
            o_read_level     <= level;
            o_out_latch_vec  <= n_latch;
            o_out_enable_vec <= n_oe;
            o_pin_function   <= n_f;
            o_pin_pad_bits   <= n_p;
        end
    end

endmodule
`default_nettype wire

>>> design/gpio_pin_config_open_drain.sv
// gpio pin controller with emulated open drain: usage
// command channel: i_valid with o_stall; a beat carries command, port, pin,
//   argument and the sampled pin levels
// result channel: o_valid with i_stall; one result beat per command beat,
//   carrying status, read level, latch and enable vectors and the
//   function and pad word of the addressed pin after the command
// a command is first captured into the input registers; its update then loads
//   the result register, and no new command is accepted until that update has
//   run, which is the read-modify-write of the per-pin register file
// a new command is accepted while an earlier result still waits; its update
//   waits until the result register is free
// receiver stall: the result holds unchanged and further commands back up
//   through o_stall
// reset: all pins get no function and an isolated pull-down schmitt pad,
//   latch, enable and open-drain vectors clear, no result pending
`default_nettype none
module gpio_pin_config_open_drain #(
    parameter int PIN_COUNT = 30
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [3:0]  i_command,
    input  wire  [7:0]  i_port_id,
    input  wire  [4:0]  i_pin_index,
    input  wire  [4:0]  i_argument,
    input  wire  [29:0] i_pin_levels,
    output logic        o_valid,
    input  wire         i_stall,
    output logic        o_status,
    output logic        o_read_level,
    output logic [29:0] o_out_latch_vec,
    output logic [29:0] o_out_enable_vec,
    output logic [4:0]  o_pin_function,
    output logic [8:0]  o_pin_pad_bits
);

    gpc_pkg::t_ctrl_cmd cmd;

    gpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    gpc_dp #(
        .PIN_COUNT (PIN_COUNT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_command        (i_command),
        .i_port_id        (i_port_id),
        .i_pin_index      (i_pin_index),
        .i_argument       (i_argument),
        .i_pin_levels     (i_pin_levels),
        .o_status         (o_status),
        .o_read_level     (o_read_level),
        .o_out_latch_vec  (o_out_latch_vec),
        .o_out_enable_vec (o_out_enable_vec),
        .o_pin_function   (o_pin_function),
        .o_pin_pad_bits   (o_pin_pad_bits)
    );

endmodule
`default_nettype wire

>>> tb/tb_gpio_pin_config_open_drain.sv
// testbench of the gpio pin controller: directed and random commands checked against a predictor
module tb_gpio_pin_config_open_drain;
    import gpc_pkg::*;

    localparam int PIN_COUNT   = 30;
    localparam int IDLE_PCT    = 37;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [3:0] CMD_UNKNOWN_FIRST = 4'd9;
    localparam logic [3:0] CMD_UNKNOWN_LAST  = 4'd15;
    localparam logic [7:0] PORT_GOOD         = 8'd0;
    localparam logic [7:0] PORT_BAD          = 8'hff;

    typedef struct packed {
        logic              status;
        logic              read_level;
        logic [29:0]       latch;
        logic [29:0]       enable;
        logic [FUNC_W-1:0] func;
        logic [PAD_W-1:0]  pad;
    } t_pin_result;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        i_stall      = 1'b0;
    logic [3:0]  i_command    = '0;
    logic [7:0]  i_port_id    = '0;
    logic [4:0]  i_pin_index  = '0;
    logic [4:0]  i_argument   = '0;
    logic [29:0] i_pin_levels = '0;
    logic        o_stall;
    logic        o_valid;
    logic        o_status;
    logic        o_read_level;
    logic [29:0] o_out_latch_vec;
    logic [29:0] o_out_enable_vec;
    logic [4:0]  o_pin_function;
    logic [8:0]  o_pin_pad_bits;

    gpio_pin_config_open_drain #(
        .PIN_COUNT(PIN_COUNT)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_port_id       (i_port_id),
        .i_pin_index     (i_pin_index),
        .i_argument      (i_argument),
        .i_pin_levels    (i_pin_levels),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_read_level    (o_read_level),
        .o_out_latch_vec (o_out_latch_vec),
        .o_out_enable_vec(o_out_enable_vec),
        .o_pin_function  (o_pin_function),
        .o_pin_pad_bits  (o_pin_pad_bits)
    );

    logic [FUNC_W-1:0] func_sel [PIN_COUNT];
    logic [PAD_W-1:0]  pad_word [PIN_COUNT];
    logic [29:0]       latch_vec;
    logic [29:0]       enable_vec;
    logic [29:0]       open_drain_vec;

    t_pin_result expected_results[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    logic        no_idle        = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= no_idle ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
    end

    function automatic void reset_pin_state();
        for (int i = 0; i < PIN_COUNT; i++) begin
            func_sel[i] = FUNC_NONE;
            pad_word[i] = PAD_RESET;
        end
        latch_vec      = '0;
        enable_vec     = '0;
        open_drain_vec = '0;
    endfunction

    function automatic void pad_rmw(input int pin, input logic [PAD_W-1:0] clr,
                                    input logic [PAD_W-1:0] set);
        pad_word[pin] = (pad_word[pin] & ~clr) | set;
    endfunction

    // open-drain pins with latch high are released, all others driven
    function automatic void follow_latch(input logic [29:0] sel_bit);
        if ((open_drain_vec & sel_bit) != 0 && (latch_vec & sel_bit) != 0)
            enable_vec &= ~sel_bit;
        else
            enable_vec |= sel_bit;
    endfunction

    function automatic t_pin_result apply_command(input logic [3:0] cmd,
                                                  input logic [7:0] port,
                                                  input logic [4:0] pin,
                                                  input logic [4:0] arg,
                                                  input logic [29:0] levels);
        t_pin_result      r;
        logic             pin_ok;
        logic [29:0]      sel_bit;
        logic             bad;
        logic             level;
        logic [PAD_W-1:0] slew;
        pin_ok   = pin < PIN_COUNT;
        sel_bit  = pin_ok ? (30'd1 << pin) : '0;
        bad      = 1'b0;
        level    = 1'b0;
        if (port != PORT_GOOD) begin
            bad = 1'b1;
        end else if (cmd == CMD_PROBE) begin
            open_drain_vec = '0;
        end else if (!pin_ok || cmd > CMD_READ) begin
            bad = 1'b1;
        end else begin
            case (cmd)
                CMD_MODE: begin
                    case (arg)
                        MODE_INPUT: begin
                            func_sel[pin] = FUNC_SIO;
                            pad_rmw(pin, PAD_ISO | PAD_IE, PAD_SCHMITT | PAD_IE);
                            enable_vec &= ~sel_bit;
                        end
                        MODE_OUTPUT: begin
                            func_sel[pin] = FUNC_SIO;
                            pad_rmw(pin, PAD_ISO | PAD_IE, PAD_SCHMITT | PAD_IE);
                            if ((open_drain_vec & sel_bit) != 0)
                                latch_vec |= sel_bit;
                            follow_latch(sel_bit);
                        end
                        MODE_ALT: begin
                            pad_rmw(pin, PAD_ISO | PAD_IE, PAD_SCHMITT | PAD_IE);
                            enable_vec &= ~sel_bit;
                        end
                        MODE_ANALOG: begin
                            func_sel[pin] = FUNC_NONE;
                            pad_rmw(pin, PAD_ISO | PAD_IE | PAD_SCHMITT, '0);
                            enable_vec &= ~sel_bit;
                        end
                        default: bad = 1'b1;
                    endcase
                end
                CMD_PULL: begin
                    case (arg)
                        PULL_NONE: pad_rmw(pin, PAD_PUE | PAD_PDE, '0);
                        PULL_UP:   pad_rmw(pin, PAD_PUE | PAD_PDE, PAD_PUE);
                        PULL_DOWN: pad_rmw(pin, PAD_PUE | PAD_PDE, PAD_PDE);
                        default:   bad = 1'b1;
                    endcase
                end
                CMD_TYPE: begin
                    case (arg)
                        TYPE_PUSH_PULL:  open_drain_vec &= ~sel_bit;
                        TYPE_OPEN_DRAIN: open_drain_vec |= sel_bit;
                        default:         bad = 1'b1;
                    endcase
                    if (!bad)
                        follow_latch(sel_bit);
                end
                CMD_ALTF: begin
                    if (arg > FUNC_MAX)
                        bad = 1'b1;
                    else
                        func_sel[pin] = arg;
                end
                CMD_SPEED: begin
                    if (arg > SPEED_MAX) begin
                        bad = 1'b1;
                    end else begin
                        slew = (arg >= SPEED_FAST_SLEW) ? PAD_SLEW : 9'd0;
                        pad_rmw(pin, PAD_DRIVE | PAD_SLEW,
                                (PAD_W'(arg) << PAD_DRIVE_SHIFT) | slew);
                    end
                end
                CMD_SET: begin
                    latch_vec |= sel_bit;
                    if ((open_drain_vec & sel_bit) != 0)
                        enable_vec &= ~sel_bit;
                end
                CMD_CLEAR: begin
                    latch_vec &= ~sel_bit;
                    if ((open_drain_vec & sel_bit) != 0)
                        enable_vec |= sel_bit;
                end
                default: level = (levels & sel_bit) != 0;
            endcase
        end
        r.status     = bad;
        r.read_level = bad ? 1'b0 : level;
        r.latch      = latch_vec;
        r.enable     = enable_vec;
        r.func       = pin_ok ? func_sel[pin] : '0;
        r.pad        = pin_ok ? pad_word[pin] : '0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got 0x%0h expected 0x%0h", what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_pin_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result beat with nothing pending",
                                32'(o_out_latch_vec), 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_read_level !== want.read_level)
                    report_mismatch("read_level", 32'(o_read_level),
                                    32'(want.read_level));
                if (o_out_latch_vec !== want.latch)
                    report_mismatch("out_latch_vec", 32'(o_out_latch_vec),
                                    32'(want.latch));
                if (o_out_enable_vec !== want.enable)
                    report_mismatch("out_enable_vec", 32'(o_out_enable_vec),
                                    32'(want.enable));
                if (o_pin_function !== want.func)
                    report_mismatch("pin_function", 32'(o_pin_function),
                                    32'(want.func));
                if (o_pin_pad_bits !== want.pad)
                    report_mismatch("pin_pad_bits", 32'(o_pin_pad_bits),
                                    32'(want.pad));
            end
        end
    end

    task automatic send_command(input logic [3:0] cmd, input logic [7:0] port,
                                input logic [4:0] pin, input logic [4:0] arg,
                                input logic [29:0] levels);
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_port_id    <= port;
        i_pin_index  <= pin;
        i_argument   <= arg;
        i_pin_levels <= levels;
        do @(posedge i_clk); while (o_stall);
        expected_results.push_back(apply_command(cmd, port, pin, arg, levels));
    endtask

    task automatic test_directed();
        send_command(CMD_READ, PORT_GOOD, 5'd0, 5'd0, '1);
        send_command(CMD_READ, PORT_GOOD, 5'd29, 5'd0, 30'h15555555);
        send_command(CMD_SET, PORT_BAD, 5'd3, 5'd0, '0);
        send_command(CMD_SET, PORT_GOOD, 5'd30, 5'd0, '0);
        send_command(CMD_READ, PORT_GOOD, 5'd31, 5'd0, '1);
        send_command(CMD_UNKNOWN_FIRST, PORT_GOOD, 5'd1, 5'd0, '0);
        send_command(CMD_UNKNOWN_LAST, PORT_GOOD, 5'd1, 5'd31, '1);
        send_command(CMD_MODE, PORT_GOOD, 5'd2, MODE_ANALOG + 5'd1, '0);
        send_command(CMD_PULL, PORT_GOOD, 5'd2, PULL_DOWN + 5'd1, '0);
        send_command(CMD_TYPE, PORT_GOOD, 5'd2, TYPE_OPEN_DRAIN + 5'd1, '0);
        send_command(CMD_ALTF, PORT_GOOD, 5'd2, FUNC_MAX + 5'd1, '0);
        send_command(CMD_SPEED, PORT_GOOD, 5'd2, SPEED_MAX + 5'd1, '0);
        send_command(CMD_ALTF, PORT_GOOD, 5'd2, FUNC_MAX, '0);
        send_command(CMD_MODE, PORT_GOOD, 5'd2, MODE_OUTPUT, '0);
        send_command(CMD_MODE, PORT_GOOD, 5'd2, MODE_INPUT, '0);
        send_command(CMD_MODE, PORT_GOOD, 5'd3, MODE_ALT, '0);
        send_command(CMD_MODE, PORT_GOOD, 5'd3, MODE_ANALOG, '0);
        send_command(CMD_PULL, PORT_GOOD, 5'd4, PULL_UP, '0);
        send_command(CMD_SPEED, PORT_GOOD, 5'd5, SPEED_MAX, '0);
        send_command(CMD_TYPE, PORT_GOOD, 5'd29, TYPE_OPEN_DRAIN, '0);
        send_command(CMD_SET, PORT_GOOD, 5'd29, 5'd0, '0);
        send_command(CMD_MODE, PORT_GOOD, 5'd29, MODE_OUTPUT, '0);
        send_command(CMD_CLEAR, PORT_GOOD, 5'd29, 5'd0, '0);
        send_command(CMD_PROBE, PORT_GOOD, 5'd31, 5'd0, '0);
        send_command(CMD_PROBE, PORT_BAD, 5'd0, 5'd0, '0);
    endtask

    // mostly well-formed commands on a few busy pins, the rest fully random
    task automatic test_random_traffic(input int count);
        logic [3:0] cmd;
        logic [7:0] port;
        logic [4:0] pin;
        logic [4:0] arg;
        int         pick;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 15) begin
                cmd  = 4'($urandom_range(15));
                port = ($urandom_range(3) == 0) ? PORT_GOOD : 8'($urandom_range(255));
                pin  = 5'($urandom_range(31));
                arg  = 5'($urandom_range(31));
            end else begin
                port = PORT_GOOD;
                pin  = 5'(($urandom_range(99) < 60) ? $urandom_range(3)
                                                    : $urandom_range(29));
                arg  = 5'($urandom_range(31));
                pick = $urandom_range(99);
                if (pick < 3) begin
                    cmd = CMD_PROBE;
                end else if (pick < 15) begin
                    cmd = CMD_MODE;
                    arg = 5'($urandom_range(MODE_ANALOG));
                end else if (pick < 23) begin
                    cmd = CMD_PULL;
                    arg = 5'($urandom_range(PULL_DOWN));
                end else if (pick < 38) begin
                    cmd = CMD_TYPE;
                    arg = 5'($urandom_range(TYPE_OPEN_DRAIN));
                end else if (pick < 46) begin
                    cmd = CMD_ALTF;
                    arg = 5'($urandom_range(FUNC_MAX));
                end else if (pick < 54) begin
                    cmd = CMD_SPEED;
                    arg = 5'($urandom_range(SPEED_MAX));
                end else if (pick < 70) begin
                    cmd = CMD_SET;
                end else if (pick < 86) begin
                    cmd = CMD_CLEAR;
                end else begin
                    cmd = CMD_READ;
                end
            end
            send_command(cmd, port, pin, arg, 30'($urandom));
        end
    endtask

    task automatic test_drain_and_resume();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        test_random_traffic(20);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        test_random_traffic(200);
        no_idle = 1'b0;
    endtask

    initial begin
        reset_pin_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_traffic(700);
        test_drain_and_resume();
        test_back_to_back();
        test_random_traffic(680);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
